// ----- hdl/dwsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_pkg
// widths, constants and shared types of the dual wheel speed pid core
// ----------------------------------------------------------------------------
package dwsp_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int GAIN_W         = 24;
    localparam int SPEED_W        = 16;
    localparam int ERR_W          = SPEED_W + 1;
    localparam int DIFF_W         = ERR_W + 1;
    localparam int INT_W          = 32;
    localparam int DUTY_W         = 15;
    localparam int PROD_P_W       = GAIN_W + ERR_W;
    localparam int PROD_I_W       = GAIN_W + INT_W;
    localparam int PROD_D_W       = GAIN_W + DIFF_W;
    localparam int SUM_W          = PROD_I_W + 2;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 4;
    localparam int STAGES         = 5;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = DUTY_W'(25000);

    typedef enum logic [1:0] {
        REG_GAIN_P     = 2'd0,
        REG_GAIN_I     = 2'd1,
        REG_GAIN_D     = 2'd2,
        REG_DUTY_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_stage_ctl;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [DUTY_W-1:0] duty_limit;
    } t_cfg;

endpackage

// ----- hdl/dwsp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_in_if
// control tick channel: run flag, encoder and target speeds
// ----------------------------------------------------------------------------
interface dwsp_in_if
    import dwsp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      run;
    logic signed [SPEED_W-1:0] encoder_left;
    logic signed [SPEED_W-1:0] encoder_right;
    logic signed [SPEED_W-1:0] target_left;
    logic signed [SPEED_W-1:0] target_right;

    modport source (
        output valid, run, encoder_left, encoder_right, target_left, target_right,
        input  ready
    );
    modport sink (
        input  valid, run, encoder_left, encoder_right, target_left, target_right,
        output ready
    );
endinterface

// ----- hdl/dwsp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_out_if
// duty result channel: direction and duty magnitude per wheel
// ----------------------------------------------------------------------------
interface dwsp_out_if
    import dwsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              dir_left;
    logic [DUTY_W-1:0] duty_left;
    logic              dir_right;
    logic [DUTY_W-1:0] duty_right;

    modport source (
        output valid, dir_left, duty_left, dir_right, duty_right,
        input  ready
    );
    modport sink (
        input  valid, dir_left, duty_left, dir_right, duty_right,
        output ready
    );
endinterface

// ----- hdl/dwsp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_cfg
// apb register bank holding the shared gains and the duty limit
// ----------------------------------------------------------------------------
module dwsp_cfg
    import dwsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= '0;
            r_cfg.gain_i     <= '0;
            r_cfg.gain_d     <= '0;
            r_cfg.duty_limit <= DUTY_LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:     r_cfg.gain_p     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     r_cfg.gain_i     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     r_cfg.gain_d     <= pwdata[GAIN_W-1:0];
                REG_DUTY_LIMIT: r_cfg.duty_limit <= pwdata[DUTY_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GAIN_P:     prdata = APB_DATA_W'(r_cfg.gain_p);
            REG_GAIN_I:     prdata = APB_DATA_W'(r_cfg.gain_i);
            REG_GAIN_D:     prdata = APB_DATA_W'(r_cfg.gain_d);
            REG_DUTY_LIMIT: prdata = {{(APB_DATA_W-DUTY_W){1'b0}}, r_cfg.duty_limit};
        endcase
    end

endmodule

// ----- hdl/dwsp_wheel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_wheel
// one wheel: error and integral update, gain products, sum, truncate, clamp
// ----------------------------------------------------------------------------
module dwsp_wheel
    import dwsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_stage_ctl                i_ctl,
    input  t_cfg                      i_cfg,
    input  logic                      i_run,
    input  logic signed [SPEED_W-1:0] i_encoder,
    input  logic signed [SPEED_W-1:0] i_target,
    output logic                      o_neg,
    output logic [DUTY_W-1:0]         o_mag
);

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // controller state
    logic signed [INT_W-1:0]    r_integral;
    logic signed [ERR_W-1:0]    r_last_err;

    // stage 1
    logic                       r_run1;
    logic signed [ERR_W-1:0]    r_err1;
    logic signed [INT_W-1:0]    r_int1;
    logic signed [DIFF_W-1:0]   r_diff1;
    // stage 2
    logic                       r_run2;
    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    // stage 3
    logic                       r_run3;
    logic signed [SUM_W-1:0]    r_sum;
    // stage 4
    logic                       r_neg;
    logic [DUTY_W-1:0]          r_mag;

    logic signed [ERR_W-1:0]    n_err;
    logic signed [INT_W:0]      n_acc;
    logic signed [INT_W-1:0]    n_int;
    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [PROD_P_W-1:0] n_prod_p;
    logic signed [PROD_I_W-1:0] n_prod_i;
    logic signed [PROD_D_W-1:0] n_prod_d;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    n_biased;
    logic signed [SUM_W-1:0]    n_q;
    logic signed [SUM_W-1:0]    n_lim;
    logic signed [SUM_W-1:0]    n_clamped;
    logic                       n_neg;
    logic [DUTY_W-1:0]          n_mag;

    always_comb begin
        n_err  = ERR_W'(i_target) - ERR_W'(i_encoder);
        n_acc  = (INT_W+1)'(r_integral) + (INT_W+1)'(n_err);
        if (n_acc[INT_W] != n_acc[INT_W-1]) begin
            n_int = n_acc[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            n_int = n_acc[INT_W-1:0];
        end
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_err);
    end

    always_comb begin
        n_prod_p = PROD_P_W'(i_cfg.gain_p) * PROD_P_W'(r_err1);
        n_prod_i = PROD_I_W'(i_cfg.gain_i) * PROD_I_W'(r_int1);
        n_prod_d = PROD_D_W'(i_cfg.gain_d) * PROD_D_W'(r_diff1);
    end

    assign n_sum = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);

    always_comb begin
        n_biased = r_sum[SUM_W-1] ? (r_sum + ROUND_BIAS) : r_sum;
        n_q      = n_biased >>> GAIN_FRAC_BITS;
        n_lim    = SUM_W'({1'b0, i_cfg.duty_limit});
        if (n_q >= n_lim) begin
            n_clamped = n_lim;
        end else if (n_q < -n_lim) begin
            n_clamped = -n_lim;
        end else begin
            n_clamped = n_q;
        end
        if (!r_run3) begin
            n_neg = 1'b0;
            n_mag = '0;
        end else begin
            n_neg = n_clamped[SUM_W-1];
            n_mag = n_neg ? DUTY_W'(-n_clamped) : n_clamped[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else if (i_ctl.ld1 && i_run) begin
            r_integral <= n_int;
            r_last_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_run1  <= i_run;
            r_err1  <= n_err;
            r_int1  <= n_int;
            r_diff1 <= n_diff;
        end
        if (i_ctl.ld2) begin
            r_run2   <= r_run1;
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (i_ctl.ld3) begin
            r_run3 <= r_run2;
            r_sum  <= n_sum;
        end
        if (i_ctl.ld4) begin
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

    assign o_neg = r_neg;
    assign o_mag = r_mag;

endmodule

// ----- hdl/dual_wheel_speed_pid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_core
// positional speed pid for two wheels with shared gains and duty clamp
//
//   channel   dir  handshake       payload
//   i_in      in   valid / ready   run, encoder_left/right, target_left/right
//   o_out     out  valid / ready   dir_left, duty_left, dir_right, duty_right
//   apb       in   psel / penable  gain_p, gain_i, gain_d, duty_limit
//
// five register stages: input, state update, products, sum, clamped duty
// one tick per cycle sustained while the output is not stalled
// synchronous active-low reset clears all stage valid flags, the state and the registers
// each stage holds under stall and empty stages keep taking ticks
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_core
    import dwsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dwsp_in_if.sink               i_in,
    dwsp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                      w_cfg;
    t_stage_ctl                w_ctl;
    logic [STAGES-1:0]         r_v;
    logic [STAGES-1:0]         w_rdy;
    logic                      r_run;
    logic signed [SPEED_W-1:0] r_enc_l;
    logic signed [SPEED_W-1:0] r_enc_r;
    logic signed [SPEED_W-1:0] r_tgt_l;
    logic signed [SPEED_W-1:0] r_tgt_r;
    logic                      w_neg_l;
    logic                      w_neg_r;
    logic [DUTY_W-1:0]         w_mag_l;
    logic [DUTY_W-1:0]         w_mag_r;

    dwsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_rdy[STAGES-1] = !r_v[STAGES-1] || o_out.ready;
        for (int k = STAGES-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        w_ctl.ld1 = r_v[0] && w_rdy[1];
        w_ctl.ld2 = r_v[1] && w_rdy[2];
        w_ctl.ld3 = r_v[2] && w_rdy[3];
        w_ctl.ld4 = r_v[3] && w_rdy[4];
    end

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_rdy[0]) begin
            r_run   <= i_in.run;
            r_enc_l <= i_in.encoder_left;
            r_enc_r <= i_in.encoder_right;
            r_tgt_l <= i_in.target_left;
            r_tgt_r <= i_in.target_right;
        end
    end

    dwsp_wheel u_wheel_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cfg     (w_cfg),
        .i_run     (r_run),
        .i_encoder (r_enc_l),
        .i_target  (r_tgt_l),
        .o_neg     (w_neg_l),
        .o_mag     (w_mag_l)
    );

    dwsp_wheel u_wheel_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cfg     (w_cfg),
        .i_run     (r_run),
        .i_encoder (r_enc_r),
        .i_target  (r_tgt_r),
        .o_neg     (w_neg_r),
        .o_mag     (w_mag_r)
    );

    // right wheel direction sense is inverted
    assign o_out.valid      = r_v[STAGES-1];
    assign o_out.dir_left   = w_neg_l;
    assign o_out.duty_left  = w_mag_l;
    assign o_out.dir_right  = !w_neg_r;
    assign o_out.duty_right = w_mag_r;

`ifndef SYNTHESIS
    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.duty_left <= w_cfg.duty_limit)
                        && (o_out.duty_right <= w_cfg.duty_limit))
        else $error("duty magnitude above limit");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> i_in.ready)
        else $error("empty pipeline refuses a transaction");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && (r_v == '0))
        else $error("stage valid left set after reset");
`endif

endmodule
